// File: sv/vsf_pkg.sv
// Shared types, register codes and fixed-point helpers for the viscous stress face flux core.
// Depends on nothing; the core and the testbench import it.
package vsf_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_VISCOSITY = 2'd0,
    CFG_TIME_STEP = 2'd1,
    CFG_FLUX_DIR  = 2'd2
  } cfg_reg_e;

  // Face normal axis codes
  typedef enum logic [1:0] {
    DIR_X = 2'd0,
    DIR_Y = 2'd1,
    DIR_Z = 2'd2
  } dir_e;

  typedef struct packed {
    logic signed [31:0] vel_u;
    logic signed [31:0] vel_v;
    logic signed [31:0] vel_w;
    logic signed [31:0] along_u;
    logic signed [31:0] along_v;
    logic signed [31:0] along_w;
    logic signed [31:0] first_side_normal;
    logic signed [31:0] first_side_own;
    logic signed [31:0] second_side_normal;
    logic signed [31:0] second_side_own;
    logic        [30:0] cell_length;
  } in_t;

  typedef struct packed {
    logic signed [31:0] flux_u;
    logic signed [31:0] flux_v;
    logic signed [31:0] flux_w;
    logic signed [31:0] flux_e;
  } out_t;

  // Cycles from operand to registered quotient in vsf_div
  function automatic int vsf_div_lat(input int q_w);
    return q_w + 3;
  endfunction

  // Clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [31:0] r;
    if (v > 72'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -72'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Arithmetic shift right that rounds toward zero
  function automatic logic signed [71:0] trunc_shr(input logic signed [71:0] v,
                                                   input int sh);
    logic signed [71:0] bias;
    bias = v[71] ? ((72'sd1 <<< sh) - 72'sd1) : 72'sd0;
    return (v + bias) >>> sh;
  endfunction

endpackage

// File: sv/vsf_dly.sv
// Enable-gated delay line that carries side data alongside a divider.
// Depends on nothing.
module vsf_dly #(
  parameter int W = 8,
  parameter int D = 2
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] pipe_q [D];

  // Shift one place per advance
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q[0] <= d_i;
      for (int i = 1; i < D; i++) begin
        pipe_q[i] <= pipe_q[i-1];
      end
    end
  end

  assign q_o = pipe_q[D-1];

endmodule

// File: sv/vsf_div.sv
// Pipelined signed restoring divider, one quotient bit per stage, quotient
// truncated toward zero and clamped to OUT_W bits. Depends on nothing.
module vsf_div #(
  parameter int NUM_W = 57,
  parameter int DEN_W = 31,
  parameter int Q_W   = 32,
  parameter int OUT_W = 32
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [NUM_W-1:0] num_i,
  input  logic        [DEN_W-1:0] den_i,
  output logic signed [OUT_W-1:0] quo_o
);

  localparam int HI_W = NUM_W - Q_W;
  localparam int CW   = (HI_W > DEN_W) ? HI_W : DEN_W;
  localparam int XW   = ((Q_W > OUT_W) ? Q_W : OUT_W) + 1;

  logic             s0_neg_q;
  logic [NUM_W-1:0] s0_mag_q;
  logic [DEN_W-1:0] s0_den_q;

  logic [DEN_W-1:0] rem_q [Q_W+1];
  logic [Q_W-1:0]   low_q [Q_W+1];
  logic [Q_W-1:0]   acc_q [Q_W+1];
  logic [DEN_W-1:0] den_q [Q_W+1];
  logic             neg_q [Q_W+1];
  logic             ovf_q [Q_W+1];

  logic [HI_W-1:0]  hi;
  logic [XW-1:0]    qx;
  logic [XW-1:0]    lim_pos;
  logic [XW-1:0]    lim_neg;

  // Take the magnitude
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s0_neg_q <= num_i[NUM_W-1];
      s0_mag_q <= num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
      s0_den_q <= den_i;
    end
  end

  // Flag a quotient too wide for Q_W bits, seed the remainder
  assign hi = s0_mag_q[NUM_W-1:Q_W];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ovf_q[0] <= CW'(hi) >= CW'(s0_den_q);
      rem_q[0] <= (CW'(hi) >= CW'(s0_den_q)) ? '0 : DEN_W'(hi);
      low_q[0] <= s0_mag_q[Q_W-1:0];
      acc_q[0] <= '0;
      den_q[0] <= s0_den_q;
      neg_q[0] <= s0_neg_q;
    end
  end

  // One compare and subtract per stage
  for (genvar k = 1; k <= Q_W; k++) begin : g_step
    logic [DEN_W:0] t;
    logic           ge;
    assign t  = {rem_q[k-1], low_q[k-1][Q_W-1]};
    assign ge = t >= {1'b0, den_q[k-1]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? DEN_W'(t - {1'b0, den_q[k-1]}) : DEN_W'(t);
        low_q[k] <= low_q[k-1] << 1;
        acc_q[k] <= (acc_q[k-1] << 1) | Q_W'(ge);
        den_q[k] <= den_q[k-1];
        neg_q[k] <= neg_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  // Apply the sign and clamp
  assign qx      = XW'(acc_q[Q_W]);
  assign lim_neg = XW'(1) << (OUT_W - 1);
  assign lim_pos = lim_neg - XW'(1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (neg_q[Q_W]) begin
        if (ovf_q[Q_W] || qx > lim_neg) begin
          quo_o <= {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
          quo_o <= OUT_W'(-qx);
        end
      end else begin
        if (ovf_q[Q_W] || qx > lim_pos) begin
          quo_o <= {1'b0, {(OUT_W-1){1'b1}}};
        end else begin
          quo_o <= OUT_W'(qx);
        end
      end
    end
  end

endmodule

// File: sv/viscous_stress_face_flux_core.sv
// Viscous stress face flux core: takes one face item per cycle while the output is not stalled and
// returns one flux item per item, in order. The pipe holds two banks of pipelined restoring dividers
// by the cell length (gradients, final dt/dx scale) that each retire one quotient bit per stage;
// the deviator's division by DIMENSIONS is a three-stage reciprocal multiply. An output stall
// freezes the whole pipe.
module viscous_stress_face_flux_core
  import vsf_pkg::*;
#(
  parameter int DIMENSIONS    = 3,
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_item_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int  F     = FRACTION_BITS;
  localparam int  GN_W  = 33 + F;
  localparam int  LG    = vsf_div_lat(32);
  localparam int  LD    = 3;
  localparam int  LO    = vsf_div_lat(32);
  localparam int  DEPTH = LG + LD + LO + 9;
  localparam bit  THREE = (DIMENSIONS == 3);
  // ceil(2^34 / DIMENSIONS); exact for magnitudes below 2^33
  localparam logic [33:0] DEV_RCP = THREE ? 34'd5726623062 : 34'h2_0000_0000;

  typedef struct packed {
    logic signed [31:0] cu;
    logic signed [31:0] cv;
    logic signed [31:0] cw;
    logic        [30:0] dx;
    logic        [1:0]  dir;
    logic               bad;
  } side_t;

  typedef struct packed {
    side_t              sd;
    logic signed [35:0] s1;
    logic signed [35:0] s2;
  } side_b_t;

  function automatic logic signed [GN_W-1:0] grad_num(input logic signed [31:0] a,
                                                      input logic signed [31:0] b);
    logic signed [32:0] d;
    d = 33'(a) - 33'(b);
    return GN_W'(d) <<< F;
  endfunction

  // Configuration registers
  logic [30:0] visc_q, dt_q;
  logic [1:0]  dir_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visc_q <= '0;
      dt_q   <= '0;
      dir_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_VISCOSITY: visc_q <= cfg_data_i[30:0];
        CFG_TIME_STEP: dt_q   <= cfg_data_i[30:0];
        CFG_FLUX_DIR:  dir_q  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // Advance the whole pipe unless the output item is held
  logic             adv;
  logic [DEPTH-1:0] vld_q;

  assign adv         = !out_valid_o || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = vld_q[DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[DEPTH-2:0], in_valid_i};
    end
  end

  // Stage 1: pick axes, form gradient numerators
  logic signed [31:0]     cur_c [3];
  logic signed [31:0]     alg_c [3];
  logic signed [31:0]     c_n, al_n, c_a1, al_a1, c_a2, al_a2;
  logic signed [GN_W-1:0] gnum [7];
  logic [30:0]            dx0;
  side_t                  s1_side_d;

  logic signed [GN_W-1:0] s1_gnum_q [7];
  side_t                  s1_side_q;

  always_comb begin
    cur_c[0] = in_item_i.vel_u;
    cur_c[1] = in_item_i.vel_v;
    cur_c[2] = THREE ? in_item_i.vel_w : '0;
    alg_c[0] = in_item_i.along_u;
    alg_c[1] = in_item_i.along_v;
    alg_c[2] = THREE ? in_item_i.along_w : '0;
    unique case (dir_e'(dir_q))
      DIR_X: begin
        c_n = cur_c[0]; al_n = alg_c[0]; c_a1 = cur_c[1]; al_a1 = alg_c[1];
        c_a2 = cur_c[2]; al_a2 = alg_c[2];
      end
      DIR_Y: begin
        c_n = cur_c[1]; al_n = alg_c[1]; c_a1 = cur_c[0]; al_a1 = alg_c[0];
        c_a2 = cur_c[2]; al_a2 = alg_c[2];
      end
      DIR_Z: begin
        c_n = cur_c[2]; al_n = alg_c[2]; c_a1 = cur_c[0]; al_a1 = alg_c[0];
        c_a2 = cur_c[1]; al_a2 = alg_c[1];
      end
      default: begin
        c_n = '0; al_n = '0; c_a1 = '0; al_a1 = '0; c_a2 = '0; al_a2 = '0;
      end
    endcase
    gnum[0] = grad_num(c_n, al_n);
    gnum[1] = grad_num(c_a1, in_item_i.first_side_own);
    gnum[2] = THREE ? grad_num(c_a2, in_item_i.second_side_own) : '0;
    gnum[3] = grad_num(c_a1, al_a1);
    gnum[4] = grad_num(c_n, in_item_i.first_side_normal);
    gnum[5] = THREE ? grad_num(c_a2, al_a2) : '0;
    gnum[6] = THREE ? grad_num(c_n, in_item_i.second_side_normal) : '0;
    dx0 = (in_item_i.cell_length == '0) ? 31'd1 : in_item_i.cell_length;
    s1_side_d.cu  = cur_c[0];
    s1_side_d.cv  = cur_c[1];
    s1_side_d.cw  = cur_c[2];
    s1_side_d.dx  = dx0;
    s1_side_d.dir = dir_q;
    s1_side_d.bad = int'(dir_q) >= DIMENSIONS;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_gnum_q <= gnum;
      s1_side_q <= s1_side_d;
    end
  end

  // Gradient dividers
  logic signed [31:0] grad_w [7];
  side_t              side_a;

  for (genvar i = 0; i < 7; i++) begin : g_grad
    vsf_div #(.NUM_W(GN_W), .DEN_W(31), .Q_W(32), .OUT_W(32)) u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (s1_gnum_q[i]),
      .den_i (s1_side_q.dx),
      .quo_o (grad_w[i])
    );
  end

  vsf_dly #(.W($bits(side_t)), .D(LG)) u_dly_a (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   (s1_side_q),
    .q_o   (side_a)
  );

  // Stage 3: deviator numerator and cross sums
  logic signed [35:0] gx [7];
  logic signed [35:0] s3_devnum_q;
  side_b_t            s3_side_q;

  always_comb begin
    for (int i = 0; i < 7; i++) begin
      gx[i] = 36'(grad_w[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_devnum_q  <= (THREE ? (gx[0] <<< 1) : gx[0]) - gx[1] - gx[2];
      s3_side_q.sd <= side_a;
      s3_side_q.s1 <= gx[3] + gx[4];
      s3_side_q.s2 <= gx[5] + gx[6];
    end
  end

  // Divide the deviator by the dimension count: take the magnitude, form the
  // reciprocal partial products, then combine, shift and restore the sign
  logic [32:0]        devnum_mag;
  logic               d1_neg_q, d2_neg_q;
  logic [32:0]        d1_mag_q;
  logic [50:0]        d2_pl_q;
  logic [49:0]        d2_ph_q;
  logic [67:0]        dev_prod;
  logic [35:0]        dev_mag;
  logic signed [35:0] dev_q;
  side_b_t            side_b;

  assign devnum_mag = s3_devnum_q[35] ? 33'(-s3_devnum_q) : 33'(s3_devnum_q);
  assign dev_prod   = (68'(d2_ph_q) << 17) + 68'(d2_pl_q);
  assign dev_mag    = 36'(dev_prod[67:34]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d1_neg_q <= s3_devnum_q[35];
      d1_mag_q <= devnum_mag;
      d2_neg_q <= d1_neg_q;
      d2_pl_q  <= 51'(d1_mag_q[16:0]) * 51'(DEV_RCP);
      d2_ph_q  <= 50'(d1_mag_q[32:17]) * 50'(DEV_RCP);
      dev_q    <= d2_neg_q ? -$signed(dev_mag) : $signed(dev_mag);
    end
  end

  vsf_dly #(.W($bits(side_b_t)), .D(LD)) u_dly_b (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   (s3_side_q),
    .q_o   (side_b)
  );

  // Stage 4: viscosity partial products
  logic signed [31:0] mu_s;
  logic signed [35:0] tx [3];
  logic signed [49:0] pl_d [3];
  logic signed [50:0] ph_d [3];
  logic signed [49:0] s4_pl_q [3];
  logic signed [50:0] s4_ph_q [3];
  side_t              s4_side_q;

  always_comb begin
    mu_s  = $signed({1'b0, visc_q});
    tx[0] = dev_q;
    tx[1] = side_b.s1;
    tx[2] = side_b.s2;
    for (int k = 0; k < 3; k++) begin
      pl_d[k] = mu_s * $signed({1'b0, tx[k][16:0]});
      ph_d[k] = mu_s * $signed(tx[k][35:17]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_pl_q   <= pl_d;
      s4_ph_q   <= ph_d;
      s4_side_q <= side_b.sd;
    end
  end

  // Stage 5: combine partial products
  logic signed [67:0] s5_p_q [3];
  side_t              s5_side_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s5_p_q[k] <= (68'(s4_ph_q[k]) <<< 17) + 68'(s4_pl_q[k]);
      end
      s5_side_q <= s4_side_q;
    end
  end

  // Stage 6: scale to stress and map to components
  logic signed [31:0] tau_n, tau_1, tau_2;
  logic signed [31:0] tau_d [3];
  logic signed [31:0] s6_tau_q [3];
  side_t              s6_side_q;

  always_comb begin
    tau_n = sat32(trunc_shr(72'(s5_p_q[0]), F - 1));
    tau_1 = sat32(trunc_shr(72'(s5_p_q[1]), F));
    tau_2 = sat32(trunc_shr(72'(s5_p_q[2]), F));
    unique case (dir_e'(s5_side_q.dir))
      DIR_X:   begin tau_d[0] = tau_n; tau_d[1] = tau_1; tau_d[2] = tau_2; end
      DIR_Y:   begin tau_d[0] = tau_1; tau_d[1] = tau_n; tau_d[2] = tau_2; end
      DIR_Z:   begin tau_d[0] = tau_1; tau_d[1] = tau_2; tau_d[2] = tau_n; end
      default: begin tau_d[0] = '0;    tau_d[1] = '0;    tau_d[2] = '0;    end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s6_tau_q  <= tau_d;
      s6_side_q <= s5_side_q;
    end
  end

  // Stage 7: negate momentum, form velocity-stress products
  logic signed [31:0] cur6 [3];
  logic signed [31:0] s7_flux_q [3];
  logic signed [63:0] s7_prod_q [3];
  logic [30:0]        s7_dx_q;
  logic               s7_bad_q;

  always_comb begin
    cur6[0] = s6_side_q.cu;
    cur6[1] = s6_side_q.cv;
    cur6[2] = s6_side_q.cw;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        s7_flux_q[c] <= sat32(-72'(s6_tau_q[c]));
        s7_prod_q[c] <= 64'(cur6[c]) * 64'(s6_tau_q[c]);
      end
      s7_dx_q  <= s6_side_q.dx;
      s7_bad_q <= s6_side_q.bad;
    end
  end

  // Stage 8: energy flux
  logic signed [31:0] s8_e_q;
  logic signed [31:0] s8_flux_q [3];
  logic [30:0]        s8_dx_q;
  logic               s8_bad_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s8_e_q    <= sat32(-(trunc_shr(72'(s7_prod_q[0]), F)
                         + trunc_shr(72'(s7_prod_q[1]), F)
                         + trunc_shr(72'(s7_prod_q[2]), F)));
      s8_flux_q <= s7_flux_q;
      s8_dx_q   <= s7_dx_q;
      s8_bad_q  <= s7_bad_q;
    end
  end

  // Stage 9: multiply by dt
  logic signed [31:0] dt_s;
  logic signed [63:0] s9_m_q [4];
  logic [30:0]        s9_dx_q;
  logic               s9_bad_q;

  assign dt_s = $signed({1'b0, dt_q});

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        s9_m_q[c] <= s8_flux_q[c] * dt_s;
      end
      s9_m_q[3] <= s8_e_q * dt_s;
      s9_dx_q   <= s8_dx_q;
      s9_bad_q  <= s8_bad_q;
    end
  end

  // Divide by dx
  logic signed [31:0] quo [4];
  logic               bad_o;

  for (genvar i = 0; i < 4; i++) begin : g_out
    vsf_div #(.NUM_W(64), .DEN_W(31), .Q_W(32), .OUT_W(32)) u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (s9_m_q[i]),
      .den_i (s9_dx_q),
      .quo_o (quo[i])
    );
  end

  vsf_dly #(.W(1), .D(LO)) u_dly_bad (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   (s9_bad_q),
    .q_o   (bad_o)
  );

  // Output register: zero the item for an unused direction, and the z flux in two dimensions
  out_t out_q;
  logic out_bad_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.flux_u <= bad_o ? '0 : quo[0];
      out_q.flux_v <= bad_o ? '0 : quo[1];
      out_q.flux_w <= (bad_o || !THREE) ? '0 : quo[2];
      out_q.flux_e <= bad_o ? '0 : quo[3];
      out_bad_q    <= bad_o;
    end
  end

  assign out_item_o = out_q;

  a_bad_dir_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_bad_q |-> out_item_o == '0)
    else $error("unused direction gave a nonzero flux");

  a_flat_w_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !THREE |-> out_item_o.flux_w == '0)
    else $error("z flux nonzero in two dimensions");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> vld_q == $past(vld_q))
    else $error("pipe moved during a stall");

endmodule

// File: tb/tb_viscous_stress_face_flux_core.sv
// Self-checking testbench for viscous_stress_face_flux_core: directed table then random faces,
// with an in-bench flux predictor and an in-order queue of expected flux items.
// Depends on vsf_pkg and the core RTL.
module tb_viscous_stress_face_flux_core;
  timeunit 1ns;
  timeprecision 1ps;
  import vsf_pkg::*;

  localparam int DIMS  = 3;
  localparam int FBITS = 16;
  localparam int LATENCY = 82;
  localparam longint CYCLE_LIMIT = 600000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_t         in_item_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_t        out_item_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  viscous_stress_face_flux_core #(.DIMENSIONS(DIMS), .FRACTION_BITS(FBITS)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_item_o(out_item_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor copy of the registers
  longint mu_q, dt_q;
  logic [1:0] dir_q;

  out_t flux_expected[$];
  int   n_errors;
  bit   tail_mode;
  longint cycles;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint slope(longint a, longint b, longint dx);
    return clamp32(((a - b) * (64'sd1 <<< FBITS)) / dx);
  endfunction

  // Compute the flux item for one face
  function automatic out_t face_flux(in_t f);
    out_t r;
    longint cur[3], nb[3], tau[3], fl[3];
    longint dx, gn, g1, g2, dev, e;
    int n, a1, a2;
    r = '0;
    n = int'(dir_q);
    if (n >= DIMS) return r;
    dx = longint'(f.cell_length);
    if (dx == 0) dx = 1;
    cur[0] = longint'(f.vel_u); cur[1] = longint'(f.vel_v); cur[2] = longint'(f.vel_w);
    nb[0] = longint'(f.along_u); nb[1] = longint'(f.along_v); nb[2] = longint'(f.along_w);
    if (DIMS == 2) begin
      cur[2] = 0;
      nb[2] = 0;
    end
    a1 = (n == 0) ? 1 : 0;
    a2 = (n == 2) ? 1 : 2;
    gn = slope(cur[n], nb[n], dx);
    g1 = slope(cur[a1], longint'(f.first_side_own), dx);
    g2 = (DIMS == 3) ? slope(cur[a2], longint'(f.second_side_own), dx) : 0;
    dev = (DIMS * gn - (gn + g1 + g2)) / DIMS;
    tau[n] = clamp32((mu_q * dev) / (64'sd1 <<< (FBITS - 1)));
    tau[a1] = clamp32((mu_q * (slope(cur[a1], nb[a1], dx)
              + slope(cur[n], longint'(f.first_side_normal), dx))) / (64'sd1 <<< FBITS));
    if (DIMS == 3)
      tau[a2] = clamp32((mu_q * (slope(cur[a2], nb[a2], dx)
                + slope(cur[n], longint'(f.second_side_normal), dx))) / (64'sd1 <<< FBITS));
    else
      tau[a2] = 0;
    e = 0;
    for (int c = 0; c < 3; c++) begin
      fl[c] = clamp32(-tau[c]);
      e -= (cur[c] * tau[c]) / (64'sd1 <<< FBITS);
    end
    e = clamp32(e);
    r.flux_u = 32'(clamp32((fl[0] * dt_q) / dx));
    r.flux_v = 32'(clamp32((fl[1] * dt_q) / dx));
    r.flux_w = (DIMS == 3) ? 32'(clamp32((fl[2] * dt_q) / dx)) : '0;
    r.flux_e = 32'(clamp32((e * dt_q) / dx));
    return r;
  endfunction

  task automatic idle_cycles(int n);
    repeat (n) @(posedge clk_i);
  endtask

  // Write one register while the core is idle
  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_VISCOSITY: mu_q = longint'(val[30:0]);
      CFG_TIME_STEP: dt_q = longint'(val[30:0]);
      default:       dir_q = val[1:0];
    endcase
    @(posedge clk_i);
  endtask

  // Send one face; optional random gap first, valid stays high after the item
  task automatic send_face(in_t f);
    if (!tail_mode && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      idle_cycles($urandom_range(1, 19));
    end
    in_valid_i <= 1'b1;
    in_item_i  <= f;
    do @(posedge clk_i); while (!in_ready_o);
    flux_expected.push_back(face_flux(f));
  endtask

  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    while (flux_expected.size() != 0) @(posedge clk_i);
    idle_cycles(LATENCY + 10);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 1) ? 32'(signed'($urandom_range(0, 20)) <<< 16)
                                     : -(32'($urandom_range(0, 20)) <<< 16);
      default: return $urandom();
    endcase
  endfunction

  function automatic in_t rand_face();
    in_t f;
    f.vel_u = rand_word(); f.vel_v = rand_word(); f.vel_w = rand_word();
    f.along_u = rand_word(); f.along_v = rand_word(); f.along_w = rand_word();
    f.first_side_normal = rand_word(); f.first_side_own = rand_word();
    f.second_side_normal = rand_word(); f.second_side_own = rand_word();
    case ($urandom_range(0, 5))
      0: f.cell_length = 31'($urandom_range(0, 3));
      1: f.cell_length = 31'h7FFF_FFFF;
      2: f.cell_length = 31'($urandom_range(1, 4)) << 16;
      default: f.cell_length = 31'($urandom());
    endcase
    return f;
  endfunction

  function automatic in_t fill_face(logic [31:0] v, logic [30:0] dx);
    in_t f;
    f = '{v, v, v, ~v, ~v, ~v, v, ~v, ~v, v, dx};
    return f;
  endfunction

  // Directed rows: face, optional hand-read expectation
  typedef struct {
    in_t  face;
    bit   typed;
    out_t want;
  } face_row_t;

  face_row_t rows[$];

  // Random output stalls outside tail mode
  initial begin
    wait (rst_ni);
    forever begin
      if (tail_mode) begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        idle_cycles($urandom_range(1, 40));
        out_ready_i <= 1'b0;
        idle_cycles($urandom_range(1, 19));
      end
    end
  end

  // Check flux items in order
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (flux_expected.size() == 0) begin
        $display("%0t unexpected flux item %h", $time, out_item_o);
        n_errors++;
      end else begin
        out_t w;
        w = flux_expected.pop_front();
        if (out_item_o.flux_u !== w.flux_u) begin
          $display("%0t flux_u expected %h actual %h", $time, w.flux_u, out_item_o.flux_u);
          n_errors++;
        end
        if (out_item_o.flux_v !== w.flux_v) begin
          $display("%0t flux_v expected %h actual %h", $time, w.flux_v, out_item_o.flux_v);
          n_errors++;
        end
        if (out_item_o.flux_w !== w.flux_w) begin
          $display("%0t flux_w expected %h actual %h", $time, w.flux_w, out_item_o.flux_w);
          n_errors++;
        end
        if (out_item_o.flux_e !== w.flux_e) begin
          $display("%0t flux_e expected %h actual %h", $time, w.flux_e, out_item_o.flux_e);
          n_errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_viscous_stress_face_flux_core: errors");
      $finish;
    end
  end

  initial begin
    logic [31:0] mus[4];
    logic [31:0] dts[4];
    int total;
    n_errors = 0;
    cycles = 0;
    tail_mode = 0;
    mu_q = 0; dt_q = 0; dir_q = DIR_X;
    idle_cycles(7);
    rst_ni <= 1'b1;
    idle_cycles(2);

    // After reset mu = dt = 0: every flux is zero
    rows.push_back('{fill_face(32'h7FFF_FFFF, 31'h1), 1, '0});
    rows.push_back('{fill_face(32'h8000_0000, 31'h0), 1, '0});
    foreach (rows[i]) begin
      send_face(rows[i].face);
      if (rows[i].typed) flux_expected[$] = rows[i].want;
    end
    drain_and_settle();
    rows.delete();

    // Directed: extremes over every direction plus an invalid one
    write_reg(CFG_VISCOSITY, 32'h0001_0000);
    write_reg(CFG_TIME_STEP, 32'h0001_0000);
    for (int d = 0; d < 4; d++) begin
      write_reg(CFG_FLUX_DIR, d);
      rows.delete();
      rows.push_back('{fill_face(32'h7FFF_FFFF, 31'h0), 0, '0});
      rows.push_back('{fill_face(32'h8000_0000, 31'h7FFF_FFFF), 0, '0});
      rows.push_back('{fill_face(32'h0002_0000, 31'h0001_0000), 0, '0});
      rows.push_back('{fill_face(32'h0, 31'h1), 0, '0});
      rows.push_back('{fill_face(32'hFFFF_FFFF, 31'h0000_8000), 0, '0});
      foreach (rows[i]) begin
        send_face(rows[i].face);
        // Invalid direction gives all-zero fluxes
        if (d == 3) flux_expected[$] = '0;
      end
      drain_and_settle();
    end

    // Random phases across register settings, extremes included
    mus = '{32'h0, 32'h7FFF_FFFF, 32'h0001_0000, 32'h0};
    dts = '{32'h7FFF_FFFF, 32'h0, 32'h0000_4000, 32'h0};
    total = 0;
    for (int p = 0; p < 10; p++) begin
      write_reg(CFG_VISCOSITY, (p < 3) ? mus[p] : $urandom_range(0, 32'h0004_0000));
      write_reg(CFG_TIME_STEP, (p < 3) ? dts[p] : $urandom_range(0, 32'h0004_0000));
      write_reg(CFG_FLUX_DIR, (p == 9) ? 3 : p % 3);
      if (p == 9) tail_mode = 1;
      repeat (85) begin
        send_face(rand_face());
        total++;
        // Hold until every flux item is back once
        if (total == 300) begin
          in_valid_i <= 1'b0;
          while (flux_expected.size() != 0) @(posedge clk_i);
        end
      end
      drain_and_settle();
    end

    if (n_errors == 0) begin
      $display("tb_viscous_stress_face_flux_core: clean");
    end else begin
      $display("tb_viscous_stress_face_flux_core: errors");
    end
    $finish;
  end

endmodule
